FILE: src/mtc_pkg.sv
// ----------------------------------------------------------------------------
// mtc_pkg: shared definitions for the millisecond tick to calendar converter.
// Holds the field widths, the unit divisors, the packed time-of-day record
// that rides along the divider pipeline, and the table of month starts.
// ----------------------------------------------------------------------------
package mtc_pkg;

  // Default width of the millisecond timestamp.
  localparam int TIME_BITS_DEFAULT = 44;

  // Dividend bits retired per pipeline stage in the constant dividers.
  localparam int DIGIT_BITS = 16;

  // Unit divisors.
  localparam int MS_PER_SEC     = 1000;
  localparam int SEC_PER_MIN    = 60;
  localparam int MIN_PER_HOUR   = 60;
  localparam int HOUR_PER_DAY   = 24;
  localparam int DAYS_PER_WEEK  = 7;
  localparam int DAYS_PER_CYCLE = 365 * 4 + 1;

  // Day zero was a Saturday.
  localparam int WEEKDAY_BASE = 6;

  // Milliseconds below one second divided by ten: n * 205 >> 11 is exact
  // for every n below 1029.
  localparam int HUND_MUL   = 205;
  localparam int HUND_SHIFT = 11;

  // Result field widths.
  localparam int HUND_W  = 7;
  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int WDAY_W  = 3;
  localparam int YEAR_W  = 10;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;

  // Day index within a four-year cycle.
  localparam int CYC_DAY_W = $clog2(DAYS_PER_CYCLE);

  // Time-of-day fields gathered as the dividers peel them off.
  typedef struct packed {
    logic [HUND_W-1:0] hundredths;
    logic [SEC_W-1:0]  second;
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    logic [WDAY_W-1:0] weekday;
  } tod_t;

  // First day of each month counted from the start of a four-year cycle.
  // The first year of the cycle is the leap year.
  localparam logic [CYC_DAY_W-1:0] MONTH_START [4][12] = '{
    '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
      11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
    '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
      11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
    '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
      11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
    '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
      11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
  };

  // Width that holds every quotient of an in_w-bit value by d.
  function automatic int quot_width(input int in_w, input int d);
    return in_w - $clog2(d) + 1;
  endfunction

  // Reciprocal of d scaled by 2^shift, rounded up.
  function automatic longint unsigned recip_const(input int shift, input int d);
    longint unsigned span;
    span = 64'd1 << shift;
    return (span + 64'(d) - 64'd1) / 64'(d);
  endfunction

endpackage

FILE: src/mtc_const_div.sv
// ----------------------------------------------------------------------------
// mtc_const_div: pipelined division by a constant.
// Long division that retires DIGIT_BITS dividend bits per stage; each digit
// of the quotient comes from one reciprocal multiplication. Every stage has
// a valid flag, and a sideband word is carried alongside each request.
// ----------------------------------------------------------------------------
module mtc_const_div #(
  parameter int IN_W    = 44,
  parameter int DIVISOR = 1000,
  parameter int SIDE_W  = 1,
  localparam int QUOT_W = mtc_pkg::quot_width(IN_W, DIVISOR),
  localparam int REM_W  = $clog2(DIVISOR)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   dividend,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [QUOT_W-1:0] quotient,
  output logic [REM_W-1:0]  remainder,
  output logic [SIDE_W-1:0] side_out
);

  localparam int STEP_W      = mtc_pkg::DIGIT_BITS;
  localparam int N_STG       = (IN_W + STEP_W - 1) / STEP_W;
  localparam int PAD_W       = N_STG * STEP_W;
  localparam int CUR_W       = REM_W + STEP_W;
  localparam int RECIP_SHIFT = CUR_W + REM_W;
  localparam int PROD_W      = 2 * CUR_W + 1;
  localparam logic [PROD_W-1:0] RECIP =
    PROD_W'(mtc_pkg::recip_const(RECIP_SHIFT, DIVISOR));
  localparam logic [CUR_W-1:0]  DIV_C = CUR_W'(DIVISOR);

  logic              stg_valid [N_STG];
  logic [REM_W-1:0]  stg_rem   [N_STG];
  logic [PAD_W-1:0]  stg_num   [N_STG];
  logic [SIDE_W-1:0] stg_side  [N_STG];
  logic              take      [N_STG+1];

  // The last stage moves on when the receiver takes the request.
  assign take[N_STG] = out_ready;

  for (genvar g = 0; g < N_STG; g++) begin : g_stage
    logic              src_valid;
    logic [REM_W-1:0]  src_rem;
    logic [PAD_W-1:0]  src_num;
    logic [SIDE_W-1:0] src_side;
    logic [REM_W-1:0]  rem_next;
    logic [PAD_W-1:0]  num_next;
    logic [STEP_W-1:0] digit;
    logic [CUR_W-1:0]  cur;
    logic [PROD_W-1:0] prod;
    logic [STEP_W-1:0] q_digit;

    // Stage input: the port for the first stage, the previous stage otherwise.
    if (g == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_rem   = '0;
      assign src_num   = PAD_W'(dividend);
      assign src_side  = side_in;
    end else begin : g_later
      assign src_valid = stg_valid[g-1];
      assign src_rem   = stg_rem[g-1];
      assign src_num   = stg_num[g-1];
      assign src_side  = stg_side[g-1];
    end

    // A stage may load when it is empty or its content moves on.
    assign take[g] = !stg_valid[g] || take[g+1];

    // The next dividend digit joins the running remainder, which is below
    // the divisor, so the quotient digit fits in one digit and the scaled
    // reciprocal gives it exactly. The digit shifts in at the bottom of the
    // dividend word as the used dividend bits leave at the top.
    assign digit    = src_num[PAD_W-1 -: STEP_W];
    assign cur      = {src_rem, digit};
    assign prod     = PROD_W'(cur) * RECIP;
    assign q_digit  = prod[RECIP_SHIFT +: STEP_W];
    assign rem_next = REM_W'(cur - CUR_W'(q_digit) * DIV_C);
    assign num_next = PAD_W'({src_num, q_digit});

    // Stage valid flag.
    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[g] <= 1'b0;
      end else if (take[g]) begin
        stg_valid[g] <= src_valid;
      end
    end

    // Stage payload.
    always_ff @(posedge clk) begin
      if (take[g] && src_valid) begin
        stg_rem[g]  <= rem_next;
        stg_num[g]  <= num_next;
        stg_side[g] <= src_side;
      end
    end
  end

  assign in_ready  = take[0];
  assign out_valid = stg_valid[N_STG-1];
  assign quotient  = stg_num[N_STG-1][QUOT_W-1:0];
  assign remainder = stg_rem[N_STG-1];
  assign side_out  = stg_side[N_STG-1];

endmodule

FILE: src/mtc_calendar.sv
// ----------------------------------------------------------------------------
// mtc_calendar: calendar lookup and result register.
// Finds the year and month within a four-year cycle from the month-start
// table, forms the day of month and year count, and holds the result.
// ----------------------------------------------------------------------------
module mtc_calendar #(
  parameter int CYC_W = 11
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [CYC_W-1:0]                   cycle_num,
  input  logic [mtc_pkg::CYC_DAY_W-1:0]      cycle_day,
  input  mtc_pkg::tod_t                      tod,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mtc_pkg::HUND_W-1:0]         hundredths,
  output logic [mtc_pkg::SEC_W-1:0]          second,
  output logic [mtc_pkg::MIN_W-1:0]          minute,
  output logic [mtc_pkg::HOUR_W-1:0]         hour,
  output logic [mtc_pkg::WDAY_W-1:0]         weekday,
  output logic [mtc_pkg::YEAR_W-1:0]         year_offset,
  output logic [mtc_pkg::MONTH_W-1:0]        month,
  output logic [mtc_pkg::MDAY_W-1:0]         day_of_month
);

  logic                              take;
  logic [1:0]                        yr_in_cyc;
  logic [mtc_pkg::MONTH_W-1:0]       mon_idx;
  logic [mtc_pkg::YEAR_W-1:0]        year_next;
  logic [mtc_pkg::MONTH_W-1:0]       month_next;
  logic [mtc_pkg::MDAY_W-1:0]        mday_next;
  logic [mtc_pkg::CYC_DAY_W-1:0]     day_in_mon;

  assign take     = !out_valid || out_ready;
  assign in_ready = take;

  // Year within the cycle, then month within that year. The starts rise
  // monotonically, so the last start not above the day wins.
  always_comb begin
    yr_in_cyc = '0;
    for (int y = 1; y < 4; y++) begin
      if (cycle_day >= mtc_pkg::MONTH_START[y][0]) begin
        yr_in_cyc = 2'(y);
      end
    end
    mon_idx = '0;
    for (int m = 1; m < 12; m++) begin
      if (cycle_day >= mtc_pkg::MONTH_START[yr_in_cyc][m]) begin
        mon_idx = mtc_pkg::MONTH_W'(m);
      end
    end
  end

  // Four years per cycle, so the year count is the cycle number with the
  // year in the cycle appended; it wraps at the field width.
  assign year_next  = mtc_pkg::YEAR_W'({cycle_num, yr_in_cyc});
  assign month_next = mon_idx + mtc_pkg::MONTH_W'(1);
  assign day_in_mon = cycle_day - mtc_pkg::MONTH_START[yr_in_cyc][mon_idx]
                      + mtc_pkg::CYC_DAY_W'(1);
  assign mday_next  = day_in_mon[mtc_pkg::MDAY_W-1:0];

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= in_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      hundredths   <= tod.hundredths;
      second       <= tod.second;
      minute       <= tod.minute;
      hour         <= tod.hour;
      weekday      <= tod.weekday;
      year_offset  <= year_next;
      month        <= month_next;
      day_of_month <= mday_next;
    end
  end

endmodule

FILE: src/millisecond_tick_to_calendar_core.sv
// ----------------------------------------------------------------------------
// millisecond_tick_to_calendar_core: millisecond count to calendar time.
// Converts milliseconds since 2000-01-01 00:00:00 into hundredths, second,
// minute, hour, weekday, year offset, month and day of month.
// ----------------------------------------------------------------------------
// Usage:
//   A request arrives on in_valid/in_ready with time_ms; one result leaves
//   on out_valid/out_ready with all calendar fields for every request.
//   Constant dividers by 1000, 60, 60 and 24, then by 7 and 1461 on the day
//   count, retire 16 dividend bits per stage with a reciprocal multiply;
//   one month-lookup and result register stage follows.
//   Throughput is one request per cycle while the receiver takes results;
//   gaps in the stream are squeezed out.
//   Reset clears every valid flag and the block is empty afterwards.
//   When the receiver stalls, the result holds and stages fill up behind
//   it; in_ready drops only once every stage holds a request.
//   The year is wrapped to 10 bits; every fourth year counts as a leap year.
// ----------------------------------------------------------------------------
module millisecond_tick_to_calendar_core #(
  parameter int TIME_BITS = mtc_pkg::TIME_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [TIME_BITS-1:0]               time_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mtc_pkg::HUND_W-1:0]         hundredths,
  output logic [mtc_pkg::SEC_W-1:0]          second,
  output logic [mtc_pkg::MIN_W-1:0]          minute,
  output logic [mtc_pkg::HOUR_W-1:0]         hour,
  output logic [mtc_pkg::WDAY_W-1:0]         weekday,
  output logic [mtc_pkg::YEAR_W-1:0]         year_offset,
  output logic [mtc_pkg::MONTH_W-1:0]        month,
  output logic [mtc_pkg::MDAY_W-1:0]         day_of_month
);

  localparam int SEC_Q_W  = mtc_pkg::quot_width(TIME_BITS, mtc_pkg::MS_PER_SEC);
  localparam int MIN_Q_W  = mtc_pkg::quot_width(SEC_Q_W, mtc_pkg::SEC_PER_MIN);
  localparam int HOUR_Q_W = mtc_pkg::quot_width(MIN_Q_W, mtc_pkg::MIN_PER_HOUR);
  localparam int DAY_Q_W  = mtc_pkg::quot_width(HOUR_Q_W, mtc_pkg::HOUR_PER_DAY);
  localparam int CYC_Q_W  = mtc_pkg::quot_width(DAY_Q_W, mtc_pkg::DAYS_PER_CYCLE);
  localparam int MS_REM_W = $clog2(mtc_pkg::MS_PER_SEC);
  localparam int WK_REM_W = $clog2(mtc_pkg::DAYS_PER_WEEK);
  localparam int TOD_W    = $bits(mtc_pkg::tod_t);
  localparam int PROD_W   = MS_REM_W + mtc_pkg::HUND_SHIFT - 3;

  // Handshakes between the divider stages.
  logic ms_valid, ms_ready;
  logic sec_valid, sec_ready;
  logic min_valid, min_ready;
  logic hr_valid, hr_ready;
  logic wk_valid, wk_ready;
  logic cyc_valid, cyc_ready;

  logic [SEC_Q_W-1:0]                secs;
  logic [MS_REM_W-1:0]               ms_rem;
  logic [PROD_W-1:0]                 hund_prod;
  mtc_pkg::tod_t                     tod_a, tod_b, tod_b_in, tod_c, tod_c_in;
  mtc_pkg::tod_t                     tod_d, tod_d_in, tod_e, tod_e_in, tod_f;
  logic [MIN_Q_W-1:0]                mins;
  logic [mtc_pkg::SEC_W-1:0]         sec_rem;
  logic [HOUR_Q_W-1:0]               hours;
  logic [mtc_pkg::MIN_W-1:0]         min_rem;
  logic [DAY_Q_W-1:0]                days;
  logic [mtc_pkg::HOUR_W-1:0]        hour_rem;
  logic [DAY_Q_W-1:0]                days_e;
  logic [WK_REM_W-1:0]               wk_rem;
  logic [CYC_Q_W-1:0]                cyc_num;
  logic [mtc_pkg::CYC_DAY_W-1:0]     cyc_day;

  // Whole seconds and the milliseconds below them.
  mtc_const_div #(
    .IN_W    (TIME_BITS),
    .DIVISOR (mtc_pkg::MS_PER_SEC),
    .SIDE_W  (1)
  ) u_div_ms (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dividend  (time_ms),
    .side_in   (1'b0),
    .out_valid (ms_valid),
    .out_ready (ms_ready),
    .quotient  (secs),
    .remainder (ms_rem),
    .side_out  ()
  );

  // Milliseconds to hundredths by a reciprocal multiply.
  assign hund_prod = PROD_W'(ms_rem) * PROD_W'(mtc_pkg::HUND_MUL);

  always_comb begin
    tod_a            = '0;
    tod_a.hundredths = hund_prod[mtc_pkg::HUND_SHIFT +: mtc_pkg::HUND_W];
  end

  // Whole minutes and the second within the minute.
  mtc_const_div #(
    .IN_W    (SEC_Q_W),
    .DIVISOR (mtc_pkg::SEC_PER_MIN),
    .SIDE_W  (TOD_W)
  ) u_div_sec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ms_valid),
    .in_ready  (ms_ready),
    .dividend  (secs),
    .side_in   (tod_a),
    .out_valid (sec_valid),
    .out_ready (sec_ready),
    .quotient  (mins),
    .remainder (sec_rem),
    .side_out  (tod_b)
  );

  always_comb begin
    tod_b_in        = tod_b;
    tod_b_in.second = sec_rem;
  end

  // Whole hours and the minute within the hour.
  mtc_const_div #(
    .IN_W    (MIN_Q_W),
    .DIVISOR (mtc_pkg::MIN_PER_HOUR),
    .SIDE_W  (TOD_W)
  ) u_div_min (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sec_valid),
    .in_ready  (sec_ready),
    .dividend  (mins),
    .side_in   (tod_b_in),
    .out_valid (min_valid),
    .out_ready (min_ready),
    .quotient  (hours),
    .remainder (min_rem),
    .side_out  (tod_c)
  );

  always_comb begin
    tod_c_in        = tod_c;
    tod_c_in.minute = min_rem;
  end

  // Whole days and the hour within the day.
  mtc_const_div #(
    .IN_W    (HOUR_Q_W),
    .DIVISOR (mtc_pkg::HOUR_PER_DAY),
    .SIDE_W  (TOD_W)
  ) u_div_hour (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (min_valid),
    .in_ready  (min_ready),
    .dividend  (hours),
    .side_in   (tod_c_in),
    .out_valid (hr_valid),
    .out_ready (hr_ready),
    .quotient  (days),
    .remainder (hour_rem),
    .side_out  (tod_d)
  );

  always_comb begin
    tod_d_in      = tod_d;
    tod_d_in.hour = hour_rem;
  end

  // Day of week from the day count; the day count rides along for the
  // cycle split that follows.
  mtc_const_div #(
    .IN_W    (HOUR_Q_W - mtc_pkg::HOUR_W + 1),
    .DIVISOR (mtc_pkg::DAYS_PER_WEEK),
    .SIDE_W  (DAY_Q_W + TOD_W)
  ) u_div_week (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hr_valid),
    .in_ready  (hr_ready),
    .dividend  (days),
    .side_in   ({days, tod_d_in}),
    .out_valid (wk_valid),
    .out_ready (wk_ready),
    .quotient  (),
    .remainder (wk_rem),
    .side_out  ({days_e, tod_e})
  );

  // Day zero was a Saturday, so shift the remainder by the base weekday.
  always_comb begin
    tod_e_in = tod_e;
    if (wk_rem == '0) begin
      tod_e_in.weekday = mtc_pkg::WDAY_W'(mtc_pkg::WEEKDAY_BASE);
    end else begin
      tod_e_in.weekday = mtc_pkg::WDAY_W'(wk_rem - WK_REM_W'(1));
    end
  end

  // Four-year cycles and the day within the cycle.
  mtc_const_div #(
    .IN_W    (DAY_Q_W),
    .DIVISOR (mtc_pkg::DAYS_PER_CYCLE),
    .SIDE_W  (TOD_W)
  ) u_div_cyc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wk_valid),
    .in_ready  (wk_ready),
    .dividend  (days_e),
    .side_in   (tod_e_in),
    .out_valid (cyc_valid),
    .out_ready (cyc_ready),
    .quotient  (cyc_num),
    .remainder (cyc_day),
    .side_out  (tod_f)
  );

  // Year and month lookup with the result register.
  mtc_calendar #(
    .CYC_W (CYC_Q_W)
  ) u_calendar (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (cyc_valid),
    .in_ready     (cyc_ready),
    .cycle_num    (cyc_num),
    .cycle_day    (cyc_day),
    .tod          (tod_f),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hundredths   (hundredths),
    .second       (second),
    .minute       (minute),
    .hour         (hour),
    .weekday      (weekday),
    .year_offset  (year_offset),
    .month        (month),
    .day_of_month (day_of_month)
  );

endmodule
